>>> design/tisp_pkg.sv
`timescale 1ns / 1ps
// shared constants and types for the trie insert / search / prefix block
// no dependencies

package tisp_pkg;

    // default table sizes
    localparam int NODES_DEF    = 1024;
    localparam int ALPHABET_DEF = 26;

    // command codes; any other code runs as a prefix query
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_SEARCH = 2'd1;

    // sequencer states
    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EVAL  = 3'b100
    } t_state;

    // outcome of one letter step
    typedef struct packed {
        logic wr_en;     // row must be written back
        logic bump;      // a fresh node was taken
        logic miss;      // miss flag after this letter
        logic full;      // full flag after this letter
        logic found;     // query answer for a final letter
        logic overflow;  // insert overflow for a final letter
    } t_walk_ctl;

endpackage

>>> design/trie_insert_search_prefix_top.sv
`timescale 1ns / 1ps
// top level of the trie insert / search / prefix block
// depends on tisp_pkg, tisp_row_ram, tisp_walk

// usage
// - input channel (i_in_valid / o_in_stall) carries one letter per request with
//   its command (insert, exact search, prefix query) and a last-letter mark
// - output channel (o_out_valid / i_out_stall) carries one result per word, sent
//   on the request that holds the final letter: found and overflow
// - each letter is read, then evaluated: the row of the cursor node is read from the
//   node ram (registered read), then the next cursor is chosen from that row,
//   and the next letter's read address depends on it
// - a result is registered once the evaluation of its final letter finishes
// - each ram row holds all child slots of one node plus the word-end bit of
//   each child, so one read-modify-write per letter covers create and mark
// - after reset the node ram is swept to zero, one row per cycle, over all
//   NODES rows; o_in_stall stays high during the sweep
// - the output register lets the next word's letters enter while a result
//   waits; only a final letter waits in evaluation when that register is
//   still held by a stalled result

module trie_insert_search_prefix_top import tisp_pkg::*; #(
    parameter int NODES    = NODES_DEF,
    parameter int ALPHABET = ALPHABET_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_cmd,
    input  logic [4:0] i_letter,
    input  logic       i_last,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_found,
    output logic       o_overflow
);

    localparam int NB = $clog2(NODES);
    localparam int LW = $clog2(ALPHABET);
    localparam int RW = ALPHABET * (NB + 1);

    t_state        r_state;
    logic [NB-1:0] r_clr;
    logic [NB-1:0] r_cursor;
    logic [NB:0]   r_next_free;
    logic          r_miss;
    logic          r_full;
    logic [1:0]    r_cmd;
    logic [4:0]    r_letter;
    logic          r_last;
    logic          r_out_valid;
    logic          r_found;
    logic          r_overflow;

    logic          accept;
    logic          done;
    logic          ram_we;
    logic [NB-1:0] ram_waddr;
    logic [RW-1:0] ram_wdata;
    logic [RW-1:0] ram_rdata;
    t_walk_ctl     walk_ctl;
    logic [NB-1:0] walk_cursor;
    logic [RW-1:0] walk_row;

    // a letter enters only while the sequencer is idle
    assign accept = i_in_valid && (r_state == S_IDLE);
    // a final letter finishes only when the output register is free
    assign done   = (r_state == S_EVAL) && (!r_last || !r_out_valid || !i_out_stall);

    // clear sweep writes zero rows, evaluation writes the modified cursor row
    assign ram_we    = (r_state == S_CLEAR) || (done && walk_ctl.wr_en);
    assign ram_waddr = (r_state == S_CLEAR) ? r_clr : r_cursor;
    assign ram_wdata = (r_state == S_CLEAR) ? '0 : walk_row;

    tisp_row_ram #(
        .DEPTH (NODES),
        .WIDTH (RW),
        .AW    (NB)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (r_cursor),
        .o_rdata (ram_rdata)
    );

    tisp_walk #(
        .NODES    (NODES),
        .ALPHABET (ALPHABET),
        .NB       (NB),
        .LW       (LW),
        .RW       (RW)
    ) u_walk (
        .i_cmd       (r_cmd),
        .i_letter    (r_letter),
        .i_last      (r_last),
        .i_miss      (r_miss),
        .i_full      (r_full),
        .i_cursor    (r_cursor),
        .i_next_free (r_next_free),
        .i_row       (ram_rdata),
        .o_ctl       (walk_ctl),
        .o_cursor    (walk_cursor),
        .o_row       (walk_row)
    );

    // sequencer and walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_cursor    <= '0;
            r_next_free <= (NB + 1)'(1);
            r_miss      <= 1'b0;
            r_full      <= 1'b0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == NB'(NODES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (done) begin
                        r_state <= S_IDLE;
                        if (walk_ctl.bump) begin
                            r_next_free <= r_next_free + 1'b1;
                        end
                        // end of word returns the walk to the root
                        if (r_last) begin
                            r_cursor <= '0;
                            r_miss   <= 1'b0;
                            r_full   <= 1'b0;
                        end else begin
                            r_cursor <= walk_cursor;
                            r_miss   <= walk_ctl.miss;
                            r_full   <= walk_ctl.full;
                        end
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                    r_clr   <= '0;
                end
            endcase
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd    <= i_cmd;
            r_letter <= i_letter;
            r_last   <= i_last;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done && r_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done && r_last) begin
            r_found    <= walk_ctl.found;
            r_overflow <= walk_ctl.overflow;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_overflow  = r_overflow;

endmodule

>>> design/tisp_row_ram.sv
`timescale 1ns / 1ps
// single-port-write, single-port-read synchronous ram with a registered read
// no dependencies

module tisp_row_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 286,
    parameter int AW    = 10
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/tisp_walk.sv
`timescale 1ns / 1ps
// one letter step of the trie walk: decides the outcome from the cursor row
// depends on tisp_pkg

module tisp_walk import tisp_pkg::*; #(
    parameter int NODES    = NODES_DEF,
    parameter int ALPHABET = ALPHABET_DEF,
    parameter int NB       = $clog2(NODES),
    parameter int LW       = $clog2(ALPHABET),
    parameter int RW       = ALPHABET * (NB + 1)
) (
    input  logic [1:0]    i_cmd,
    input  logic [4:0]    i_letter,
    input  logic          i_last,
    input  logic          i_miss,
    input  logic          i_full,
    input  logic [NB-1:0] i_cursor,
    input  logic [NB:0]   i_next_free,
    input  logic [RW-1:0] i_row,
    output t_walk_ctl     o_ctl,
    output logic [NB-1:0] o_cursor,
    output logic [RW-1:0] o_row
);

    // each slot: {child word end, child index}; index zero means no child
    logic [ALPHABET-1:0][NB:0] row;
    logic [ALPHABET-1:0][NB:0] nrow;
    logic [LW+4:0]             letter_ext;
    logic                      in_range;
    logic [LW-1:0]             sel;
    logic [NB:0]               slot;
    logic [NB:0]               nslot;
    logic [NB-1:0]             child;
    logic [NB-1:0]             cur;
    logic                      miss;
    logic                      full;
    logic                      bump;
    logic                      ok;
    logic                      mark;

    assign row = i_row;

    always_comb begin
        letter_ext = (LW + 5)'(i_letter);
        in_range   = letter_ext < (LW + 5)'(ALPHABET);
        sel        = in_range ? letter_ext[LW-1:0] : '0;
        slot       = row[sel];
        child      = slot[NB-1:0];
        nslot      = slot;
        cur        = i_cursor;
        miss       = i_miss;
        full       = i_full;
        bump       = 1'b0;

        if (!i_miss && !i_full) begin
            if (!in_range) begin
                miss = 1'b1;
            end else if (child != '0) begin
                cur = child;
            end else if (i_cmd != CMD_INSERT) begin
                miss = 1'b1;
            end else if (i_next_free >= (NB + 1)'(NODES)) begin
                full = 1'b1;
            end else begin
                // new node, word end starts clear
                bump  = 1'b1;
                cur   = i_next_free[NB-1:0];
                nslot = {1'b0, i_next_free[NB-1:0]};
            end
        end

        ok   = !miss && !full;
        mark = i_last && ok && (i_cmd == CMD_INSERT);
        if (mark) begin
            nslot[NB] = 1'b1;
        end

        nrow      = row;
        nrow[sel] = nslot;

        o_ctl.wr_en    = bump || mark;
        o_ctl.bump     = bump;
        o_ctl.miss     = miss;
        o_ctl.full     = full;
        o_ctl.found    = (i_cmd == CMD_SEARCH) ? (ok && slot[NB])
                                               : ((i_cmd != CMD_INSERT) && ok);
        o_ctl.overflow = (i_cmd == CMD_INSERT) && full;
        o_cursor       = cur;
        o_row          = nrow;
    end

endmodule

>>> design/tisp_checker.sv
`timescale 1ns / 1ps
// port-level checks for the trie block, bound to the top level
// depends on trie_insert_search_prefix_top

module tisp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_found,
    input logic       o_overflow
);

    // reset leaves no result pending
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // each accepted letter occupies the block during its evaluation
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("letter accepted in back-to-back cycles");

    // an answer never claims both a hit and an overflow
    a_found_xor_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_found && o_overflow))
        else $error("found and overflow both set");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_found) && $stable(o_overflow)))
        else $error("stalled result changed");

endmodule

bind trie_insert_search_prefix_top tisp_checker u_tisp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_found     (o_found),
    .o_overflow  (o_overflow)
);
